>>> sv/n2a_pkg.sv
`default_nettype none

package n2a_pkg;

    localparam int DEC_DIGITS = 7;
    localparam int VALUE_W    = 24;
    localparam int SUFFIX_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;

    // Longest run of characters: all digits plus a two-character suffix.
    localparam int NCH     = DEC_DIGITS + 2;
    localparam int CNT_W   = $clog2(NCH + 1);
    localparam int LEAD_W  = $clog2(DEC_DIGITS + 1);

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    localparam logic [SUFFIX_W-1:0] SUF_NONE  = 2'd0;
    localparam logic [SUFFIX_W-1:0] SUF_COMMA = 2'd1;
    localparam logic [SUFFIX_W-1:0] SUF_CR    = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    localparam logic [63:0] DEC_LIMIT = pow10(DEC_DIGITS) - 64'd1;

    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = ASCII_ZERO + {4'b0000, nib};
        end else begin
            c = 8'h37 + {4'b0000, nib};
        end
        return c;
    endfunction

    typedef struct packed {
        logic                             mode;
        logic [SUFFIX_W-1:0]              suffix;
        logic [7:0]                       hb;
        logic [VALUE_W-1:0]               rem;
        logic [DEC_DIGITS-1:0][DIGIT_W-1:0] digits;
        logic [LEAD_W-1:0]                lead;
        logic                             started;
    } t_item;

endpackage

`default_nettype wire

>>> sv/n2a_if.sv
`default_nettype none

interface n2a_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [n2a_pkg::VALUE_W-1:0]    value;
    logic [n2a_pkg::SUFFIX_W-1:0]   suffix;

    modport source(output valid, mode, value, suffix, input ready);
    modport sink(input valid, mode, value, suffix, output ready);
endinterface

interface n2a_out_if;
    logic                           valid;
    logic                           ready;
    logic [n2a_pkg::CHAR_W-1:0]     out_char;
    logic                           last;

    modport source(output valid, out_char, last, input ready);
    modport sink(input valid, out_char, last, output ready);
endinterface

`default_nettype wire

>>> sv/number_to_ascii_formatter_top.sv
`default_nettype none

// Formats one number per input transaction as ASCII text: up to seven decimal digits with
// leading zeros dropped (saturating at 9999999), or one byte as two upper-case hex digits,
// followed by an optional ", " or carriage return. Each character leaves as its own output
// transaction, one per cycle while the output is ready, with last set on the final one.
// An item of n characters (1 to 9) therefore holds the output until all n have left, so
// the character serializer sets the sustained rate; a new item enters the pipeline in
// every cycle while the pipeline has room. From input to first character an item passes
// an input stage, one stage per decimal digit, a packing stage and the output register.
module number_to_ascii_formatter_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    n2a_in_if.sink      i_in,
    n2a_out_if.source   o_out
);

    localparam int D = n2a_pkg::DEC_DIGITS;

    n2a_pkg::t_item r_st [D+1];
    n2a_pkg::t_item n_st [D+1];
    logic [D:0]     r_vld;
    logic [D:0]     stage_en;

    logic [n2a_pkg::CHAR_W-1:0] r_pbuf [n2a_pkg::NCH];
    logic [n2a_pkg::CHAR_W-1:0] n_pbuf [n2a_pkg::NCH];
    logic [n2a_pkg::CNT_W-1:0]  r_pcnt;
    logic [n2a_pkg::CNT_W-1:0]  n_pcnt;
    logic                       r_pvld;
    logic                       pack_en;

    logic [n2a_pkg::CHAR_W-1:0] r_obuf [n2a_pkg::NCH];
    logic [n2a_pkg::CNT_W-1:0]  r_ocnt;
    logic                       out_free;
    logic                       out_take;

    // Output side: the buffer reloads once its last character goes or when it is empty.
    assign out_take = o_out.valid && o_out.ready;
    assign out_free = (r_ocnt == '0) || ((r_ocnt == n2a_pkg::CNT_W'(1)) && o_out.ready);
    assign pack_en  = !r_pvld || out_free;

    always_comb begin
        stage_en[D] = !r_vld[D] || pack_en;
        for (int i = D - 1; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
    end

    assign i_in.ready = stage_en[0];

    // Input stage: saturate the decimal value and keep the raw byte for hex.
    always_comb begin
        n_st[0]         = '0;
        n_st[0].mode    = i_in.mode;
        n_st[0].suffix  = i_in.suffix;
        n_st[0].hb      = i_in.value[7:0];
        if ({{(64 - n2a_pkg::VALUE_W){1'b0}}, i_in.value} > n2a_pkg::DEC_LIMIT) begin
            n_st[0].rem = n2a_pkg::DEC_LIMIT[n2a_pkg::VALUE_W-1:0];
        end else begin
            n_st[0].rem = i_in.value;
        end
    end

    // One stage per decimal digit, most significant first.
    for (genvar k = 0; k < D; k++) begin : g_digit
        localparam logic [63:0] P = n2a_pkg::pow10(D - 1 - k);
        logic [n2a_pkg::DIGIT_W-1:0] d;
        logic [63:0]                 sub;

        always_comb begin
            n_st[k+1] = r_st[k];
            d   = '0;
            sub = '0;
            for (int m = 1; m < 10; m++) begin
                if ({{(64 - n2a_pkg::VALUE_W){1'b0}}, r_st[k].rem} >= (64'(m) * P)) begin
                    d   = n2a_pkg::DIGIT_W'(m);
                    sub = 64'(m) * P;
                end
            end
            n_st[k+1].digits[k] = d;
            n_st[k+1].rem       = r_st[k].rem - sub[n2a_pkg::VALUE_W-1:0];
            // The final digit always prints, so it never counts as a leading zero.
            if (!r_st[k].started && (d == '0) && (k != D - 1)) begin
                n_st[k+1].lead = r_st[k].lead + n2a_pkg::LEAD_W'(1);
            end
            n_st[k+1].started = r_st[k].started || (d != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int i = 1; i <= D; i++) begin
                if (stage_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= D; i++) begin
            if (stage_en[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    // Packing stage: lay the characters out from position zero.
    always_comb begin
        logic [n2a_pkg::CNT_W-1:0]  body_n;
        logic [n2a_pkg::CNT_W-1:0]  suf_n;
        logic [n2a_pkg::CHAR_W-1:0] suf_a;
        logic [n2a_pkg::CHAR_W-1:0] suf_b;

        if (r_st[D].mode == n2a_pkg::MODE_HEX) begin
            body_n = n2a_pkg::CNT_W'(2);
        end else begin
            body_n = n2a_pkg::CNT_W'(D) - n2a_pkg::CNT_W'(r_st[D].lead);
        end

        suf_a = n2a_pkg::ASCII_COMMA;
        suf_b = n2a_pkg::ASCII_SPACE;
        case (r_st[D].suffix)
            n2a_pkg::SUF_COMMA: begin
                suf_n = n2a_pkg::CNT_W'(2);
            end
            n2a_pkg::SUF_CR: begin
                suf_n = n2a_pkg::CNT_W'(1);
                suf_a = n2a_pkg::ASCII_CR;
            end
            default: begin
                suf_n = '0;
            end
        endcase

        for (int j = 0; j < n2a_pkg::NCH; j++) begin
            n_pbuf[j] = '0;
            if (r_st[D].mode == n2a_pkg::MODE_HEX) begin
                if (j == 0) begin
                    n_pbuf[j] = n2a_pkg::hex_glyph(r_st[D].hb[7:4]);
                end else if (j == 1) begin
                    n_pbuf[j] = n2a_pkg::hex_glyph(r_st[D].hb[3:0]);
                end
            end else begin
                for (int m = 0; m < D; m++) begin
                    if (m == int'(r_st[D].lead) + j) begin
                        n_pbuf[j] = n2a_pkg::ASCII_ZERO + {4'b0000, r_st[D].digits[m]};
                    end
                end
            end
            if (n2a_pkg::CNT_W'(j) == body_n) begin
                n_pbuf[j] = suf_a;
            end else if (n2a_pkg::CNT_W'(j) == body_n + n2a_pkg::CNT_W'(1)) begin
                n_pbuf[j] = suf_b;
            end
        end
        n_pcnt = body_n + suf_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (pack_en) begin
                r_pvld <= r_vld[D];
            end
            if (out_free) begin
                r_ocnt <= r_pvld ? r_pcnt : '0;
            end else if (out_take) begin
                r_ocnt <= r_ocnt - n2a_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pack_en) begin
            r_pbuf <= n_pbuf;
            r_pcnt <= n_pcnt;
        end
        if (out_free) begin
            r_obuf <= r_pbuf;
        end else if (out_take) begin
            for (int j = 0; j < n2a_pkg::NCH - 1; j++) begin
                r_obuf[j] <= r_obuf[j+1];
            end
        end
    end

    assign o_out.valid    = (r_ocnt != '0);
    assign o_out.out_char = r_obuf[0];
    assign o_out.last     = (r_ocnt == n2a_pkg::CNT_W'(1));

endmodule

`default_nettype wire

>>> sv/n2a_checker.sv
`default_nettype none

module n2a_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [n2a_pkg::CHAR_W-1:0]  i_out_char,
    input wire logic                        i_out_last
);

    // A character waiting on a stalled output stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A comma is always followed by a space, so it never ends a run.
    a_comma_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == n2a_pkg::ASCII_COMMA) |-> !i_out_last)
        else $error("comma marked as last character");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= 8'h30) && (i_out_char <= 8'h39))
            || ((i_out_char >= 8'h41) && (i_out_char <= 8'h46))
            || (i_out_char == n2a_pkg::ASCII_COMMA)
            || (i_out_char == n2a_pkg::ASCII_SPACE)
            || (i_out_char == n2a_pkg::ASCII_CR))
        else $error("unexpected output character");

endmodule

bind number_to_ascii_formatter_top n2a_checker u_n2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last)
);

`default_nettype wire
